/* sv/ibp_pkg.sv */
// ibp_pkg: beat types, opcode attribute table and constants for the
// instruction boundary predecoder
// no dependencies
package ibp_pkg;

  localparam int ADDR_W = 16;

  localparam logic [7:0] PREFIX_BYTE = 8'hCB;

  // attribute bits: [1:0] immediate byte count
  localparam int AT_BRK_BIT = 2;
  localparam int AT_ABS_BIT = 3;
  localparam int AT_REL_BIT = 4;
  localparam int AT_UND_BIT = 7;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       buffer_end;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] instr_address;
    logic [1:0]        instr_length;
    logic [7:0]        first_byte;
    logic [15:0]       operand_value;
    logic              is_data;
    logic              breaks_flow;
    logic              target_valid;
    logic [ADDR_W-1:0] target_address;
    logic              closes_buffer;
  } out_beat_t;

  function automatic logic [7:0] op_attr(input logic [7:0] op);
    logic [7:0] a;
    case (op)
      8'h01, 8'h08, 8'h11, 8'h21, 8'h31: a = 8'h02;
      8'h06, 8'h0E, 8'h10, 8'h16, 8'h1E: a = 8'h01;
      8'h26, 8'h2E, 8'h36, 8'h3E:        a = 8'h01;
      8'h18:                             a = 8'h15;
      8'h20, 8'h28, 8'h30, 8'h38:        a = 8'h11;
      8'hC2, 8'hCA, 8'hD2, 8'hDA:        a = 8'h0A;
      8'hC3:                             a = 8'h0E;
      8'hC4, 8'hCC, 8'hCD, 8'hD4, 8'hDC: a = 8'h02;
      8'hEA, 8'hFA:                      a = 8'h02;
      8'hC6, 8'hCE, 8'hD6, 8'hDE:        a = 8'h01;
      8'hE0, 8'hE6, 8'hE8, 8'hEE:        a = 8'h01;
      8'hF0, 8'hF6, 8'hF8, 8'hFE:        a = 8'h01;
      8'hC9, 8'hD9, 8'hE9:               a = 8'h04;
      8'hD3, 8'hDB, 8'hDD, 8'hE3, 8'hE4: a = 8'h80;
      8'hEB, 8'hEC, 8'hED, 8'hF4, 8'hFC: a = 8'h80;
      8'hFD:                             a = 8'h80;
      default:                           a = 8'h00;
    endcase
    return a;
  endfunction

endpackage

/* sv/instruction_boundary_predecoder.sv */
// instruction_boundary_predecoder: splits a code byte stream into instructions,
// one byte beat in per cycle, at most one instruction beat out per byte beat.
// A beat passes through the input register, then the result register, with
// the attribute lookup and phase update between them; a new byte is taken
// every cycle as long as the result register can drain.
// depends on ibp_pkg and ibp_decode
module instruction_boundary_predecoder
  import ibp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_beat_t         out_data
);

  logic [ADDR_W-1:0] base_address;
  logic              stage_valid;
  in_beat_t          stage_beat;
  logic              step;
  logic              emit;
  out_beat_t         result;

  assign step     = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (cfg_write) begin
      base_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_beat <= in_data;
    end
  end

  ibp_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .base_address (base_address),
    .step         (step),
    .beat         (stage_beat),
    .emit         (emit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_data <= result;
    end
  end

endmodule

/* sv/ibp_decode.sv */
// ibp_decode: boundary tracking state and result formation for one byte beat
// depends on ibp_pkg
module ibp_decode
  import ibp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] base_address,
  input  logic              step,
  input  in_beat_t          beat,
  output logic              emit,
  output out_beat_t         result
);

  logic [15:0]       byte_position;
  logic [7:0]        held_opcode;
  logic [1:0]        bytes_still_needed;
  logic [7:0]        low_operand_byte;
  logic [ADDR_W-1:0] start_address;

  logic [15:0]       byte_position_next;
  logic [7:0]        held_opcode_next;
  logic [1:0]        bytes_still_needed_next;
  logic [7:0]        low_operand_byte_next;
  logic [ADDR_W-1:0] start_address_next;

  logic [ADDR_W-1:0] addr;
  logic [7:0]        attr_new;
  logic [7:0]        attr_held;
  logic [7:0]        b;
  logic              last;

  function automatic out_beat_t data_item(input logic [ADDR_W-1:0] a, input logic [7:0] op,
                                          input logic closes);
    out_beat_t r;
    r                = '0;
    r.instr_address  = a;
    r.instr_length   = 2'd1;
    r.first_byte     = op;
    r.is_data        = 1'b1;
    r.closes_buffer  = closes;
    return r;
  endfunction

  function automatic out_beat_t instr_item(input logic [ADDR_W-1:0] a, input logic [7:0] op,
                                           input logic [7:0] at, input logic [15:0] operand,
                                           input logic closes);
    out_beat_t r;
    r                = '0;
    r.instr_address  = a;
    r.instr_length   = at[1:0] + 2'd1;
    r.first_byte     = op;
    r.operand_value  = operand;
    r.breaks_flow    = at[AT_BRK_BIT];
    r.closes_buffer  = closes;
    if (at[AT_REL_BIT]) begin
      r.target_valid   = 1'b1;
      r.target_address = a + ADDR_W'(2) + {{(ADDR_W-8){operand[7]}}, operand[7:0]};
    end else if (at[AT_ABS_BIT]) begin
      r.target_valid   = 1'b1;
      r.target_address = operand[ADDR_W-1:0];
    end
    return r;
  endfunction

  assign b         = beat.code_byte;
  assign last      = beat.buffer_end;
  assign addr      = base_address + byte_position[ADDR_W-1:0];
  assign attr_new  = op_attr(b);
  assign attr_held = op_attr(held_opcode);

  always_comb begin
    emit                    = 1'b0;
    result                  = '0;
    held_opcode_next        = held_opcode;
    bytes_still_needed_next = bytes_still_needed;
    low_operand_byte_next   = low_operand_byte;
    start_address_next      = start_address;
    if (bytes_still_needed == 2'd0) begin
      start_address_next = addr;
      held_opcode_next   = b;
      if (b == PREFIX_BYTE) begin
        if (last) begin
          emit   = 1'b1;
          result = data_item(addr, b, 1'b1);
        end else begin
          bytes_still_needed_next = 2'd1;
        end
      end else if (attr_new[AT_UND_BIT]) begin
        emit   = 1'b1;
        result = data_item(addr, b, last);
      end else if (attr_new[1:0] == 2'd0) begin
        emit   = 1'b1;
        result = instr_item(addr, b, attr_new, 16'h0000, last);
      end else if (last) begin
        emit   = 1'b1;
        result = data_item(addr, b, 1'b1);
      end else begin
        bytes_still_needed_next = attr_new[1:0];
      end
    end else begin
      if (held_opcode == PREFIX_BYTE) begin
        emit                    = 1'b1;
        result.instr_address    = start_address;
        result.instr_length     = 2'd2;
        result.first_byte       = PREFIX_BYTE;
        result.operand_value    = {8'h00, b};
        result.closes_buffer    = last;
        bytes_still_needed_next = 2'd0;
      end else if (attr_held[1:0] == 2'd2 && bytes_still_needed == 2'd2) begin
        low_operand_byte_next   = b;
        bytes_still_needed_next = 2'd1;
        if (last) begin
          emit   = 1'b1;
          result = data_item(start_address, held_opcode, 1'b1);
        end
      end else begin
        emit   = 1'b1;
        result = instr_item(start_address, held_opcode, attr_held,
                            (attr_held[1:0] == 2'd2) ? {b, low_operand_byte} : {8'h00, b},
                            last);
        bytes_still_needed_next = 2'd0;
      end
    end
    if (last) begin
      byte_position_next      = 16'h0000;
      bytes_still_needed_next = 2'd0;
    end else begin
      byte_position_next = byte_position + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      held_opcode        <= '0;
      bytes_still_needed <= '0;
      low_operand_byte   <= '0;
      start_address      <= '0;
    end else if (step) begin
      byte_position      <= byte_position_next;
      held_opcode        <= held_opcode_next;
      bytes_still_needed <= bytes_still_needed_next;
      low_operand_byte   <= low_operand_byte_next;
      start_address      <= start_address_next;
    end
  end

endmodule
